[rtl/core/rs_gf256_systematic_encoder_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the Reed-Solomon encoder
// Concurrent assertion forms used by the encoder back end.
// ---------------------------------------------------------------------------
`ifndef RS_GF256_SYSTEMATIC_ENCODER_ASSERT_SVH
`define RS_GF256_SYSTEMATIC_ENCODER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define RSENC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("encoder assertion failed");

// The consequent holds in the cycle after the antecedent.
`define RSENC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("encoder assertion failed");

`endif

[rtl/core/rsenc_pkg.sv]
// ---------------------------------------------------------------------------
// Reed-Solomon encoder package
// Constants, queue entry and control types, and GF(256) arithmetic.
// ---------------------------------------------------------------------------
package rsenc_pkg;

	localparam int MAX_PARITY_DEF = 32;
	localparam int CNT_W = 6;
	localparam int RESET_PARITY = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [8:0] FIELD_POLY = 9'h11D;
	localparam logic [7:0] SYM_MASK = 8'hFF;
	localparam logic [7:0] ALPHA = 8'h02;

	typedef logic [7:0] sym_t;

	typedef struct packed {
		sym_t sym;
		logic end_now;
		logic parity_after;
	} entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic clear;
	} gen_ctrl_t;

	function automatic sym_t gf_xtime(sym_t a);
		logic [8:0] x;
		x = {a, 1'b0};
		if (x[8]) begin
			x = x ^ FIELD_POLY;
		end
		return x[7:0] & SYM_MASK;
	endfunction

	function automatic sym_t gf_mul(sym_t a, sym_t b);
		sym_t x;
		sym_t acc;
		acc = '0;
		x = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		return acc;
	endfunction

endpackage

[rtl/core/rsenc_if.sv]
// ---------------------------------------------------------------------------
// Encoder stream interfaces
// Message word channel and codeword word channel with valid/ready.
// ---------------------------------------------------------------------------
interface rsenc_msg_if;
	logic valid;
	logic ready;
	logic [7:0] message_byte;
	logic message_end;

	modport source (output valid, output message_byte, output message_end, input ready);
	modport sink (input valid, input message_byte, input message_end, output ready);
endinterface

interface rsenc_code_if;
	logic valid;
	logic ready;
	logic [7:0] code_byte;
	logic is_parity;
	logic codeword_end;

	modport source (output valid, output code_byte, output is_parity, output codeword_end,
		input ready);
	modport sink (input valid, input code_byte, input is_parity, input codeword_end,
		output ready);
endinterface

[rtl/core/rsenc_queue.sv]
// ---------------------------------------------------------------------------
// Encoder word queue
// Short FIFO between the front and the back of the encoder.
// ---------------------------------------------------------------------------
module rsenc_queue (
	input logic clk,
	input logic arst_n,
	input rsenc_pkg::entry_t push_data,
	input logic push_valid,
	output logic push_ready,
	output rsenc_pkg::entry_t pop_data,
	output logic pop_valid,
	input logic pop_ready
);

	localparam int DEPTH = rsenc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rsenc_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (fill_q != CNT_W'(DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/core/rsenc_front.sv]
// ---------------------------------------------------------------------------
// Encoder front end
// Holds the parity count, rebuilds the generator one root per cycle,
// and accepts and classifies message words into the queue.
// ---------------------------------------------------------------------------
module rsenc_front #(
	parameter int MAX_PARITY = rsenc_pkg::MAX_PARITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [rsenc_pkg::CNT_W-1:0] cfg_wdata,
	rsenc_msg_if.sink msg,
	output rsenc_pkg::entry_t push_data,
	output logic push_valid,
	input logic push_ready,
	output rsenc_pkg::gen_ctrl_t gen_ctrl,
	output rsenc_pkg::sym_t gen_coeffs [MAX_PARITY+1]
);

	localparam int CW = rsenc_pkg::CNT_W;
	localparam int RESET_COUNT = (rsenc_pkg::RESET_PARITY > MAX_PARITY) ?
		MAX_PARITY : rsenc_pkg::RESET_PARITY;

	logic [CW-1:0] count_q;
	logic [CW-1:0] step_q;
	logic [CW-1:0] sat_count;
	logic busy_q;
	rsenc_pkg::sym_t root_q;
	rsenc_pkg::sym_t gen_q [MAX_PARITY+1];
	rsenc_pkg::sym_t gen_nxt [MAX_PARITY+1];
	logic open;

	always_comb begin
		if ({1'b0, cfg_wdata} > (CW + 1)'(MAX_PARITY)) begin
			sat_count = CW'(MAX_PARITY);
		end else begin
			sat_count = cfg_wdata;
		end
	end

	always_comb begin
		gen_nxt[0] = gen_q[0];
		for (int j = 1; j <= MAX_PARITY; j++) begin
			gen_nxt[j] = gen_q[j] ^ rsenc_pkg::gf_mul(gen_q[j-1], root_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(RESET_COUNT);
			step_q <= '0;
			busy_q <= 1'b1;
			root_q <= rsenc_pkg::ALPHA;
			gen_q[0] <= 8'h01;
			for (int j = 1; j <= MAX_PARITY; j++) begin
				gen_q[j] <= '0;
			end
		end else if (cfg_we) begin
			count_q <= sat_count;
			step_q <= '0;
			busy_q <= (sat_count != '0);
			root_q <= rsenc_pkg::ALPHA;
			gen_q[0] <= 8'h01;
			for (int j = 1; j <= MAX_PARITY; j++) begin
				gen_q[j] <= '0;
			end
		end else if (busy_q) begin
			gen_q <= gen_nxt;
			root_q <= rsenc_pkg::gf_xtime(root_q);
			step_q <= step_q + 1'b1;
			if (step_q == count_q - 1'b1) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign gen_coeffs = gen_q;
	assign gen_ctrl.count = count_q;
	assign gen_ctrl.clear = cfg_we;

	assign open = !busy_q && !cfg_we;
	assign push_valid = msg.valid && open;
	assign msg.ready = push_ready && open;

	assign push_data.sym = msg.message_byte;
	assign push_data.end_now = msg.message_end && (count_q == '0);
	assign push_data.parity_after = msg.message_end && (count_q != '0);

endmodule

[rtl/core/rsenc_back.sv]
// ---------------------------------------------------------------------------
// Encoder back end
// Runs the parity LFSR, passes message words through and shifts out
// the parity words into the output register.
// ---------------------------------------------------------------------------
`include "rs_gf256_systematic_encoder_assert.svh"

module rsenc_back #(
	parameter int MAX_PARITY = rsenc_pkg::MAX_PARITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input rsenc_pkg::gen_ctrl_t gen_ctrl,
	input rsenc_pkg::sym_t gen_coeffs [MAX_PARITY+1],
	input rsenc_pkg::entry_t pop_data,
	input logic pop_valid,
	output logic pop_ready,
	rsenc_code_if.source code
);

	localparam int CW = rsenc_pkg::CNT_W;

	rsenc_pkg::sym_t par_q [MAX_PARITY];
	rsenc_pkg::sym_t par_upd [MAX_PARITY];
	rsenc_pkg::sym_t par_shf [MAX_PARITY];
	rsenc_pkg::sym_t fb;
	logic [CW-1:0] rem_q;
	logic par_busy_q;
	logic out_valid_q;
	rsenc_pkg::sym_t out_byte_q;
	logic out_parity_q;
	logic out_end_q;
	logic out_free;

	assign out_free = !out_valid_q || code.ready;
	assign pop_ready = out_free && !par_busy_q;
	assign fb = pop_data.sym ^ par_q[0];

	for (genvar j = 0; j < MAX_PARITY; j++) begin : g_lane
		if (j + 1 < MAX_PARITY) begin : g_mid
			assign par_upd[j] = (((j + 1) < int'(gen_ctrl.count)) ? par_q[j+1] : 8'h00) ^
				rsenc_pkg::gf_mul(fb, gen_coeffs[j+1]);
			assign par_shf[j] = par_q[j+1];
		end else begin : g_top
			assign par_upd[j] = rsenc_pkg::gf_mul(fb, gen_coeffs[j+1]);
			assign par_shf[j] = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			par_busy_q <= 1'b0;
			rem_q <= '0;
			for (int j = 0; j < MAX_PARITY; j++) begin
				par_q[j] <= '0;
			end
		end else begin
			if (out_free) begin
				if (par_busy_q) begin
					out_valid_q <= 1'b1;
					par_q <= par_shf;
					rem_q <= rem_q - 1'b1;
					if (rem_q == CW'(1)) begin
						par_busy_q <= 1'b0;
					end
				end else if (pop_valid) begin
					out_valid_q <= 1'b1;
					if (gen_ctrl.count != '0) begin
						par_q <= par_upd;
					end
					if (pop_data.parity_after) begin
						par_busy_q <= 1'b1;
						rem_q <= gen_ctrl.count;
					end
				end else begin
					out_valid_q <= 1'b0;
				end
			end
			if (gen_ctrl.clear) begin
				par_busy_q <= 1'b0;
				rem_q <= '0;
				for (int j = 0; j < MAX_PARITY; j++) begin
					par_q[j] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (par_busy_q) begin
				out_byte_q <= par_q[0];
				out_parity_q <= 1'b1;
				out_end_q <= (rem_q == CW'(1));
			end else if (pop_valid) begin
				out_byte_q <= pop_data.sym;
				out_parity_q <= 1'b0;
				out_end_q <= pop_data.end_now;
			end
		end
	end

	assign code.valid = out_valid_q;
	assign code.code_byte = out_byte_q;
	assign code.is_parity = out_parity_q;
	assign code.codeword_end = out_end_q;

	`RSENC_ASSERT_SAME(a_rem_live, clk, arst_n, par_busy_q, rem_q != '0)
	`RSENC_ASSERT_NEXT(a_par_drained, clk, arst_n,
		out_free && par_busy_q && (rem_q == CW'(1)) && !gen_ctrl.clear, par_q[0] == 8'h00)
	`RSENC_ASSERT_NEXT(a_par_burst, clk, arst_n,
		code.valid && code.ready && code.is_parity && !code.codeword_end && !gen_ctrl.clear,
		code.valid && code.is_parity)

endmodule

[rtl/core/rs_gf256_systematic_encoder.sv]
// ---------------------------------------------------------------------------
// Systematic Reed-Solomon encoder over GF(256)
// Passes message words through and appends the parity words of each message.
// ---------------------------------------------------------------------------
// A message word passes through the queue and then the output register.
// Throughput: one word per cycle while code.ready is high and no parity is shifting out; a
// last word adds parity_count parity words from the LFSR. After reset and each parity_count
// write, the generator is built one root per cycle, with msg.ready low meanwhile.
// Reset sets parity_count to 16, clears the queue, the output register and the parity LFSR.
module rs_gf256_systematic_encoder #(
	parameter int MAX_PARITY = rsenc_pkg::MAX_PARITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [rsenc_pkg::CNT_W-1:0] cfg_wdata,
	rsenc_msg_if.sink msg,
	rsenc_code_if.source code
);

	rsenc_pkg::entry_t push_data;
	logic push_valid;
	logic push_ready;
	rsenc_pkg::entry_t pop_data;
	logic pop_valid;
	logic pop_ready;
	rsenc_pkg::gen_ctrl_t gen_ctrl;
	rsenc_pkg::sym_t gen_coeffs [MAX_PARITY+1];

	rsenc_front #(
		.MAX_PARITY(MAX_PARITY)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.msg(msg),
		.push_data(push_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.gen_ctrl(gen_ctrl),
		.gen_coeffs(gen_coeffs)
	);

	rsenc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_data(push_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.pop_data(pop_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready)
	);

	rsenc_back #(
		.MAX_PARITY(MAX_PARITY)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.gen_ctrl(gen_ctrl),
		.gen_coeffs(gen_coeffs),
		.pop_data(pop_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.code(code)
	);

endmodule
